[rtl/assert_macros.svh]
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that a property holds at every clock edge outside of reset.
`define CHK_HOLDS(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Check that a trigger implies a consequence in the same cycle.
`define CHK_SAME(label, clk, rst_n, trig, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |-> (cons)) else $error(msg);

// Check that a trigger implies a consequence in the next cycle.
`define CHK_NEXT(label, clk, rst_n, trig, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cons)) else $error(msg);

`endif

[rtl/dqsa_pkg.sv]
package dqsa_pkg;

	// Defaults for the top level parameters
	localparam int DEPTH_DEF      = 16;
	localparam int DATA_WIDTH_DEF = 32;

	// Width of the data ports
	localparam int OUT_W = 32;

	// Operation codes
	typedef enum logic [1:0] {
		MODE_ENQ  = 2'd0,
		MODE_DEQ  = 2'd1,
		MODE_PEEK = 2'd2
	} mode_t;

	// Queue select codes
	typedef enum logic {
		SEL_LEFT  = 1'b0,
		SEL_RIGHT = 1'b1
	} qsel_t;

	// Result status codes
	typedef enum logic [1:0] {
		ST_OK       = 2'd0,
		ST_OVERFLOW = 2'd1,
		ST_EMPTY    = 2'd2
	} status_t;

	// Controller states
	typedef enum logic {
		S_IDLE = 1'b0,
		S_RESP = 1'b1
	} state_t;

	// Commands from controller to datapath
	typedef struct packed {
		logic load;
		logic respond;
	} cmd_t;

endpackage

[rtl/dqsa_ctrl.sv]
module dqsa_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	output logic              done,
	output dqsa_pkg::cmd_t    cmd
);

	dqsa_pkg::state_t state_q;
	dqsa_pkg::state_t state_d;

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= dqsa_pkg::S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state and commands
	always_comb begin
		state_d     = state_q;
		cmd.load    = 1'b0;
		cmd.respond = 1'b0;
		busy        = 1'b0;
		done        = 1'b0;
		unique case (state_q)
			dqsa_pkg::S_IDLE: begin
				if (start) begin
					cmd.load = 1'b1;
					state_d  = dqsa_pkg::S_RESP;
				end
			end
			dqsa_pkg::S_RESP: begin
				busy        = 1'b1;
				done        = 1'b1;
				cmd.respond = 1'b1;
				state_d     = dqsa_pkg::S_IDLE;
			end
			default: begin
				state_d = dqsa_pkg::S_IDLE;
			end
		endcase
	end

endmodule

[rtl/dqsa_dpath.sv]
module dqsa_dpath #(
	parameter int DEPTH      = dqsa_pkg::DEPTH_DEF,
	parameter int DATA_WIDTH = dqsa_pkg::DATA_WIDTH_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  dqsa_pkg::cmd_t                     cmd,
	input  logic                               queue_select,
	input  logic [1:0]                         mode,
	input  logic signed [dqsa_pkg::OUT_W-1:0]  data_in,
	output logic [1:0]                         status,
	output logic signed [dqsa_pkg::OUT_W-1:0]  data_out,
	output logic                               left_empty,
	output logic                               right_empty,
	output logic                               array_full
);

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);
	localparam logic [AW-1:0]   TOP_IDX = AW'(DEPTH - 1);
	localparam logic [CW:0]     DEPTH_X = (CW + 1)'(DEPTH);

	// Shared store, no reset: entries reach the output only after being written
	logic [DATA_WIDTH-1:0] mem [DEPTH];

	// Left queue: rear count (entries written since it was last empty) and front index; right queue likewise from the top
	logic [CW-1:0] lcnt_q, rcnt_q, lcnt_d, rcnt_d;
	logic [AW-1:0] lf_q, rf_q, lf_d, rf_d;

	logic                  wr_en;
	logic [AW-1:0]         wr_addr;
	logic [AW-1:0]         rd_addr;
	logic [DATA_WIDTH-1:0] wr_data;
	logic [DATA_WIDTH-1:0] rd_data_q;
	logic                  rd_ok_d, rd_ok_q;
	dqsa_pkg::status_t     status_d, status_q;
	logic [dqsa_pkg::OUT_W-1:0] rd_ext;
	logic                  full;

	// Fit the port data to the store width and back
	generate
		if (DATA_WIDTH <= dqsa_pkg::OUT_W) begin : g_wr_narrow
			assign wr_data = data_in[DATA_WIDTH-1:0];
		end else begin : g_wr_wide
			assign wr_data = {{(DATA_WIDTH - dqsa_pkg::OUT_W){1'b0}}, data_in};
		end
		if (DATA_WIDTH >= dqsa_pkg::OUT_W) begin : g_rd_wide
			assign rd_ext = rd_data_q[dqsa_pkg::OUT_W-1:0];
		end else begin : g_rd_narrow
			assign rd_ext = {{(dqsa_pkg::OUT_W - DATA_WIDTH){1'b0}}, rd_data_q};
		end
	endgenerate

	// Flags follow the pointer registers
	assign full        = ({1'b0, lcnt_q} + {1'b0, rcnt_q}) >= DEPTH_X;
	assign left_empty  = (lcnt_q == '0);
	assign right_empty = (rcnt_q == '0);
	assign array_full  = full;

	// Decode the operation and work out the next pointers
	always_comb begin
		lcnt_d   = lcnt_q;
		rcnt_d   = rcnt_q;
		lf_d     = lf_q;
		rf_d     = rf_q;
		wr_en    = 1'b0;
		wr_addr  = lcnt_q[AW-1:0];
		rd_addr  = (queue_select == dqsa_pkg::SEL_RIGHT) ? rf_q : lf_q;
		rd_ok_d  = 1'b0;
		status_d = dqsa_pkg::ST_OK;
		unique case (mode)
			dqsa_pkg::MODE_ENQ: begin
				if (full) begin
					status_d = dqsa_pkg::ST_OVERFLOW;
				end else if (queue_select == dqsa_pkg::SEL_LEFT) begin
					wr_en   = 1'b1;
					wr_addr = lcnt_q[AW-1:0];
					lcnt_d  = lcnt_q + CW'(1);
				end else begin
					wr_en   = 1'b1;
					wr_addr = TOP_IDX - rcnt_q[AW-1:0];
					rcnt_d  = rcnt_q + CW'(1);
				end
			end
			dqsa_pkg::MODE_DEQ, dqsa_pkg::MODE_PEEK: begin
				if (queue_select == dqsa_pkg::SEL_LEFT) begin
					if (lcnt_q == '0) begin
						status_d = dqsa_pkg::ST_EMPTY;
					end else begin
						rd_ok_d = 1'b1;
						if (mode == dqsa_pkg::MODE_DEQ) begin
							// Drop back to the empty marker once the front passes the rear
							if ((CW'(lf_q) + CW'(1)) == lcnt_q) begin
								lcnt_d = '0;
								lf_d   = '0;
							end else begin
								lf_d = lf_q + AW'(1);
							end
						end
					end
				end else begin
					if (rcnt_q == '0) begin
						status_d = dqsa_pkg::ST_EMPTY;
					end else begin
						rd_ok_d = 1'b1;
						if (mode == dqsa_pkg::MODE_DEQ) begin
							if (((CW + 1)'(rf_q) + (CW + 1)'(rcnt_q)) <= DEPTH_X) begin
								rcnt_d = '0;
								rf_d   = TOP_IDX;
							end else begin
								rf_d = rf_q - AW'(1);
							end
						end
					end
				end
			end
			default: begin
				status_d = dqsa_pkg::ST_OK;
			end
		endcase
	end

	// Pointer registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lcnt_q <= '0;
			rcnt_q <= '0;
			lf_q   <= '0;
			rf_q   <= TOP_IDX;
		end else if (cmd.load) begin
			lcnt_q <= lcnt_d;
			rcnt_q <= rcnt_d;
			lf_q   <= lf_d;
			rf_q   <= rf_d;
		end
	end

	// Store write and registered read
	always_ff @(posedge clk) begin
		if (cmd.load && wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (cmd.load) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	// Hold the result fields for the response cycle
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			status_q <= status_d;
			rd_ok_q  <= rd_ok_d;
		end
	end

	assign status   = status_q;
	assign data_out = (cmd.respond && rd_ok_q) ? rd_ext : '0;

endmodule

[rtl/dual_queue_shared_array.sv]
// Two FIFO queues in one store of DEPTH entries: the left queue fills upward from
// entry 0, the right one downward from the top, and neither wraps. An operation is
// taken when start is high and busy is low; its result appears on the result ports
// with done high for exactly one cycle, the cycle right after the transfer, and is
// not held, so the receiver must take it then. The controller holds busy high
// through the result cycle, so a new operation is not taken until its result
// has been shown. A freed entry is reused only after its queue drains empty.
module dual_queue_shared_array #(
	parameter int DEPTH      = dqsa_pkg::DEPTH_DEF,
	parameter int DATA_WIDTH = dqsa_pkg::DATA_WIDTH_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               start,
	output logic                               busy,
	input  logic                               queue_select,
	input  logic [1:0]                         mode,
	input  logic signed [dqsa_pkg::OUT_W-1:0]  data_in,
	output logic                               done,
	output logic [1:0]                         status,
	output logic signed [dqsa_pkg::OUT_W-1:0]  data_out,
	output logic                               left_empty,
	output logic                               right_empty,
	output logic                               array_full
);

	dqsa_pkg::cmd_t cmd;

	// Sequence each transfer
	dqsa_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.done   (done),
		.cmd    (cmd)
	);

	// Pointers, store and result fields
	dqsa_dpath #(
		.DEPTH      (DEPTH),
		.DATA_WIDTH (DATA_WIDTH)
	) u_dpath (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.queue_select (queue_select),
		.mode         (mode),
		.data_in      (data_in),
		.status       (status),
		.data_out     (data_out),
		.left_empty   (left_empty),
		.right_empty  (right_empty),
		.array_full   (array_full)
	);

endmodule

[rtl/dqsa_checker.sv]
`include "assert_macros.svh"

module dqsa_checker (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               start,
	input  logic                               busy,
	input  logic                               done,
	input  logic [1:0]                         status,
	input  logic signed [dqsa_pkg::OUT_W-1:0]  data_out,
	input  logic                               array_full
);

	logic accept;
	assign accept = start && !busy;

	// Every transfer gets its result in the next cycle
	`CHK_NEXT(a_result_follows, clk, arst_n, accept, done, "no result after transfer")
	// A result lasts one cycle
	`CHK_NEXT(a_result_single, clk, arst_n, done, !done, "result repeated")
	// No transfer while a result is shown
	`CHK_SAME(a_busy_on_result, clk, arst_n, done, busy, "busy low during result")
	// Overflow only when the rears meet
	`CHK_SAME(a_overflow_full, clk, arst_n, done && (status == dqsa_pkg::ST_OVERFLOW), array_full, "overflow while not full")
	// Failed operations return zero data
	`CHK_SAME(a_fail_zero, clk, arst_n, done && (status != dqsa_pkg::ST_OK), data_out == '0, "nonzero data on failure")

endmodule

bind dual_queue_shared_array dqsa_checker u_dqsa_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.start      (start),
	.busy       (busy),
	.done       (done),
	.status     (status),
	.data_out   (data_out),
	.array_full (array_full)
);
